// ----- rtl/ctc_pkg.sv -----
`default_nettype none
package ctc_pkg;

  localparam int unsigned MsPerSecondReset     = 1000;
  localparam int unsigned BlinkHalfPeriodReset = 500;

  localparam logic [1:0] MODE_EDIT    = 2'd0;
  localparam logic [1:0] MODE_RUNNING = 2'd1;
  localparam logic [1:0] MODE_PAUSED  = 2'd2;
  localparam logic [1:0] MODE_DONE    = 2'd3;

  localparam logic [1:0] KIND_TICK    = 2'd0;
  localparam logic [1:0] KIND_ENCODER = 2'd1;
  localparam logic [1:0] KIND_TAP     = 2'd2;

  localparam logic [1:0] HL_MINUTES   = 2'd0;
  localparam logic [1:0] HL_SECONDS   = 2'd1;
  localparam logic [1:0] HL_NONE      = 2'd2;

  localparam logic CFG_MS_PER_SECOND     = 1'b0;
  localparam logic CFG_BLINK_HALF_PERIOD = 1'b1;

  localparam logic [6:0] MAX_MIN = 7'd99;
  localparam logic [5:0] MAX_SEC = 6'd59;

  localparam logic [7:0] DIGIT_Y_LO  = 8'd75;
  localparam logic [7:0] DIGIT_Y_HI  = 8'd115;
  localparam logic [7:0] DIGIT_X_MID = 8'd120;
  localparam logic [7:0] BTN_X_LO    = 8'd70;
  localparam logic [7:0] BTN_X_HI    = 8'd170;
  localparam logic [7:0] BTN_Y_LO    = 8'd175;
  localparam logic [7:0] BTN_Y_HI    = 8'd205;

  typedef struct packed {
    logic [1:0] kind;
    logic       step_up;
    logic [7:0] touch_x;
    logic [7:0] touch_y;
  } ctc_in_t;

  typedef struct packed {
    logic [1:0] mode;
    logic [6:0] minutes_shown;
    logic [5:0] seconds_shown;
    logic [1:0] highlight;
    logic [1:0] button_label;
    logic       digits_on;
    logic       buzzer_trigger;
  } ctc_out_t;

endpackage
`default_nettype wire

// ----- rtl/ctc_core.sv -----
`default_nettype none
module ctc_core
  import ctc_pkg::*;
#(
  parameter int unsigned MS_PER_SECOND_RST     = MsPerSecondReset,
  parameter int unsigned BLINK_HALF_PERIOD_RST = BlinkHalfPeriodReset
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [15:0] cfg_wdata,
  input  wire logic        fire,
  input  wire ctc_in_t     item,
  output ctc_out_t         result
);

  // remaining time is kept as minutes and seconds; it is always loaded from
  // in-range set values, so this matches a plain seconds count
  logic [15:0] ms_per_sec_r, blink_half_r;
  logic [1:0]  mode_r, mode_nxt;
  logic [6:0]  set_min_r, set_min_nxt;
  logic [5:0]  set_sec_r, set_sec_nxt;
  logic [6:0]  rem_min_r, rem_min_nxt;
  logic [5:0]  rem_sec_r, rem_sec_nxt;
  logic        sec_sel_r, sec_sel_nxt;
  logic [15:0] ms_cnt_r, ms_cnt_nxt;
  logic [15:0] blink_cnt_r, blink_cnt_nxt;
  logic        phase_r, phase_nxt;
  logic        buzz;
  logic        editable;
  logic        on_button;
  logic        live_nxt;

  assign editable  = (mode_r == MODE_EDIT) || (mode_r == MODE_PAUSED);
  assign on_button = (item.touch_x >= BTN_X_LO) && (item.touch_x <= BTN_X_HI) &&
                     (item.touch_y >= BTN_Y_LO) && (item.touch_y <= BTN_Y_HI);

  always_comb begin
    mode_nxt      = mode_r;
    set_min_nxt   = set_min_r;
    set_sec_nxt   = set_sec_r;
    rem_min_nxt   = rem_min_r;
    rem_sec_nxt   = rem_sec_r;
    sec_sel_nxt   = sec_sel_r;
    ms_cnt_nxt    = ms_cnt_r;
    blink_cnt_nxt = blink_cnt_r;
    phase_nxt     = phase_r;
    buzz          = 1'b0;
    case (item.kind)
      KIND_TICK: begin
        if (mode_r == MODE_RUNNING) begin
          if (({1'b0, ms_cnt_r} + 17'd1) >= {1'b0, ms_per_sec_r}) begin
            ms_cnt_nxt = '0;
            if ((rem_min_r == '0) && (rem_sec_r <= 6'd1)) begin
              rem_sec_nxt   = '0;
              mode_nxt      = MODE_DONE;
              phase_nxt     = 1'b1;
              blink_cnt_nxt = '0;
              buzz          = 1'b1;
            end else if (rem_sec_r == '0) begin
              rem_min_nxt = rem_min_r - 7'd1;
              rem_sec_nxt = MAX_SEC;
            end else begin
              rem_sec_nxt = rem_sec_r - 6'd1;
            end
          end else begin
            ms_cnt_nxt = ms_cnt_r + 16'd1;
          end
        end else if (mode_r == MODE_DONE) begin
          if (({1'b0, blink_cnt_r} + 17'd1) >= {1'b0, blink_half_r}) begin
            blink_cnt_nxt = '0;
            phase_nxt     = ~phase_r;
          end else begin
            blink_cnt_nxt = blink_cnt_r + 16'd1;
          end
        end
      end
      KIND_ENCODER: begin
        if (editable) begin
          if (!sec_sel_r) begin
            if (item.step_up) begin
              set_min_nxt = (set_min_r >= MAX_MIN) ? '0 : set_min_r + 7'd1;
            end else begin
              set_min_nxt = (set_min_r == '0 || set_min_r > MAX_MIN) ?
                            MAX_MIN : set_min_r - 7'd1;
            end
          end else begin
            if (item.step_up) begin
              set_sec_nxt = (set_sec_r >= MAX_SEC) ? '0 : set_sec_r + 6'd1;
            end else begin
              set_sec_nxt = (set_sec_r == '0 || set_sec_r > MAX_SEC) ?
                            MAX_SEC : set_sec_r - 6'd1;
            end
          end
        end
      end
      KIND_TAP: begin
        if (editable && item.touch_y >= DIGIT_Y_LO && item.touch_y <= DIGIT_Y_HI) begin
          sec_sel_nxt = (item.touch_x >= DIGIT_X_MID);
        end
        if (on_button) begin
          case (mode_r)
            MODE_EDIT: begin
              rem_min_nxt = set_min_r;
              rem_sec_nxt = set_sec_r;
              if ((set_min_r != '0) || (set_sec_r != '0)) begin
                mode_nxt   = MODE_RUNNING;
                ms_cnt_nxt = '0;
              end
            end
            MODE_RUNNING: begin
              mode_nxt    = MODE_PAUSED;
              set_min_nxt = rem_min_r;
              set_sec_nxt = rem_sec_r;
            end
            MODE_PAUSED: begin
              rem_min_nxt = set_min_r;
              rem_sec_nxt = set_sec_r;
              mode_nxt    = MODE_RUNNING;
              ms_cnt_nxt  = '0;
            end
            default: begin
              mode_nxt  = MODE_EDIT;
              phase_nxt = 1'b1;
            end
          endcase
        end
      end
      default: ;
    endcase
  end

  assign live_nxt = (mode_nxt == MODE_RUNNING) || (mode_nxt == MODE_DONE);

  always_comb begin
    result.mode           = mode_nxt;
    result.minutes_shown  = live_nxt ? rem_min_nxt : set_min_nxt;
    result.seconds_shown  = live_nxt ? rem_sec_nxt : set_sec_nxt;
    result.highlight      = ((mode_nxt == MODE_EDIT) || (mode_nxt == MODE_PAUSED)) ?
                            (sec_sel_nxt ? HL_SECONDS : HL_MINUTES) : HL_NONE;
    result.button_label   = mode_nxt;
    result.digits_on      = (mode_nxt != MODE_DONE) || phase_nxt;
    result.buzzer_trigger = buzz;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ms_per_sec_r <= 16'(MS_PER_SECOND_RST);
      blink_half_r <= 16'(BLINK_HALF_PERIOD_RST);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MS_PER_SECOND:     ms_per_sec_r <= cfg_wdata;
        CFG_BLINK_HALF_PERIOD: blink_half_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_EDIT;
      set_min_r   <= '0;
      set_sec_r   <= '0;
      rem_min_r   <= '0;
      rem_sec_r   <= '0;
      sec_sel_r   <= 1'b0;
      ms_cnt_r    <= '0;
      blink_cnt_r <= '0;
      phase_r     <= 1'b1;
    end else if (fire) begin
      mode_r      <= mode_nxt;
      set_min_r   <= set_min_nxt;
      set_sec_r   <= set_sec_nxt;
      rem_min_r   <= rem_min_nxt;
      rem_sec_r   <= rem_sec_nxt;
      sec_sel_r   <= sec_sel_nxt;
      ms_cnt_r    <= ms_cnt_nxt;
      blink_cnt_r <= blink_cnt_nxt;
      phase_r     <= phase_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/countdown_timer_controller_top.sv -----
// Channel  Direction  Ports
// in       request    in_valid, in_stall, in_item  (one tick, encoder step or tap)
// out      request    out_valid, out_stall, out_item (status after that request)
// cfg      write      cfg_we, cfg_index, cfg_wdata
//
// One request per cycle sustained while out_stall is low; input register, then
// state update and result register in the same edge.
// rst_n is synchronous; it restores edit mode and the register defaults.
// out_stall holds the result register; the input register then fills and
// in_stall rises.
`default_nettype none
module countdown_timer_controller_top
  import ctc_pkg::*;
#(
  parameter int unsigned MS_PER_SECOND_RST     = MsPerSecondReset,
  parameter int unsigned BLINK_HALF_PERIOD_RST = BlinkHalfPeriodReset
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire ctc_in_t     in_item,
  output logic             out_valid,
  input  wire logic        out_stall,
  output ctc_out_t         out_item,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [15:0] cfg_wdata
);

  logic     s1_valid_r;
  ctc_in_t  s1_item_r;
  logic     out_valid_r;
  ctc_out_t out_item_r;
  ctc_out_t result;
  logic     advance;
  logic     accept;

  assign advance   = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = s1_valid_r && !advance;
  assign accept    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  ctc_core #(
    .MS_PER_SECOND_RST    (MS_PER_SECOND_RST),
    .BLINK_HALF_PERIOD_RST(BLINK_HALF_PERIOD_RST)
  ) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .fire     (advance),
    .item     (s1_item_r),
    .result   (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= accept || (s1_valid_r && !advance);
      out_valid_r <= advance || (out_valid_r && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item_r <= in_item;
    end
    if (advance) begin
      out_item_r <= result;
    end
  end

endmodule
`default_nettype wire

// ----- test/countdown_timer_controller_top_tb.sv -----
`default_nettype none
module countdown_timer_controller_top_tb;
  import ctc_pkg::*;

  localparam logic [1:0] KindUnused = 2'd3;
  localparam logic [12:0] SecPerMin = 13'd60;
  localparam int WatchdogLimit = 3000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  ctc_in_t in_item = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  ctc_out_t out_item;
  logic cfg_we = 1'b0;
  logic cfg_index = 1'b0;
  logic [15:0] cfg_wdata = '0;

  // timer model state
  logic [15:0] tm_ms_per_sec = 16'(MsPerSecondReset);
  logic [15:0] tm_blink_half = 16'(BlinkHalfPeriodReset);
  logic [1:0] tm_mode = MODE_EDIT;
  logic [6:0] tm_set_min = '0;
  logic [5:0] tm_set_sec = '0;
  logic [12:0] tm_remaining = '0;
  logic tm_sec_sel = 1'b0;
  logic [15:0] tm_ms_cnt = '0;
  logic [15:0] tm_blink_cnt = '0;
  logic tm_blink_on = 1'b1;

  ctc_out_t pending_status[$];
  int fail_count = 0;
  int idle_cycles = 0;
  int stall_left = 0;
  int stall_roll;
  logic quiet = 1'b0;

  logic target_set = 1'b0;
  logic [6:0] tgt_min;
  logic [5:0] tgt_sec;

  countdown_timer_controller_top i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  function automatic ctc_out_t next_status(ctc_in_t req);
    ctc_out_t s;
    logic buzz;
    logic editable;
    logic live;
    buzz = 1'b0;
    editable = (tm_mode == MODE_EDIT) || (tm_mode == MODE_PAUSED);
    case (req.kind)
      KIND_TICK: begin
        if (tm_mode == MODE_RUNNING) begin
          if ({1'b0, tm_ms_cnt} + 17'd1 >= {1'b0, tm_ms_per_sec}) begin
            tm_ms_cnt = '0;
            if (tm_remaining <= 13'd1) begin
              tm_remaining = '0;
              tm_mode = MODE_DONE;
              tm_blink_on = 1'b1;
              tm_blink_cnt = '0;
              buzz = 1'b1;
            end else begin
              tm_remaining = tm_remaining - 13'd1;
            end
          end else begin
            tm_ms_cnt = tm_ms_cnt + 16'd1;
          end
        end else if (tm_mode == MODE_DONE) begin
          if ({1'b0, tm_blink_cnt} + 17'd1 >= {1'b0, tm_blink_half}) begin
            tm_blink_cnt = '0;
            tm_blink_on = ~tm_blink_on;
          end else begin
            tm_blink_cnt = tm_blink_cnt + 16'd1;
          end
        end
      end
      KIND_ENCODER: begin
        if (editable && !tm_sec_sel) begin
          if (req.step_up) tm_set_min = (tm_set_min >= MAX_MIN) ? 7'd0 : tm_set_min + 7'd1;
          else tm_set_min = (tm_set_min == 7'd0 || tm_set_min > MAX_MIN) ?
                            MAX_MIN : tm_set_min - 7'd1;
        end else if (editable) begin
          if (req.step_up) tm_set_sec = (tm_set_sec >= MAX_SEC) ? 6'd0 : tm_set_sec + 6'd1;
          else tm_set_sec = (tm_set_sec == 6'd0 || tm_set_sec > MAX_SEC) ?
                            MAX_SEC : tm_set_sec - 6'd1;
        end
      end
      KIND_TAP: begin
        if (editable && req.touch_y >= DIGIT_Y_LO && req.touch_y <= DIGIT_Y_HI) begin
          tm_sec_sel = (req.touch_x >= DIGIT_X_MID);
        end
        if (req.touch_x >= BTN_X_LO && req.touch_x <= BTN_X_HI &&
            req.touch_y >= BTN_Y_LO && req.touch_y <= BTN_Y_HI) begin
          case (tm_mode)
            MODE_EDIT: begin
              tm_remaining = 13'(tm_set_min) * SecPerMin + 13'(tm_set_sec);
              if (tm_remaining != '0) begin
                tm_mode = MODE_RUNNING;
                tm_ms_cnt = '0;
              end
            end
            MODE_RUNNING: begin
              tm_mode = MODE_PAUSED;
              tm_set_min = 7'(tm_remaining / SecPerMin);
              tm_set_sec = 6'(tm_remaining % SecPerMin);
            end
            MODE_PAUSED: begin
              tm_remaining = 13'(tm_set_min) * SecPerMin + 13'(tm_set_sec);
              tm_mode = MODE_RUNNING;
              tm_ms_cnt = '0;
            end
            default: begin
              tm_mode = MODE_EDIT;
              tm_blink_on = 1'b1;
            end
          endcase
        end
      end
      default: ;
    endcase
    editable = (tm_mode == MODE_EDIT) || (tm_mode == MODE_PAUSED);
    live = (tm_mode == MODE_RUNNING) || (tm_mode == MODE_DONE);
    s.mode = tm_mode;
    s.minutes_shown = live ? 7'(tm_remaining / SecPerMin) : tm_set_min;
    s.seconds_shown = live ? 6'(tm_remaining % SecPerMin) : tm_set_sec;
    s.highlight = !editable ? HL_NONE : (tm_sec_sel ? HL_SECONDS : HL_MINUTES);
    s.button_label = tm_mode;
    s.digits_on = (tm_mode != MODE_DONE) || tm_blink_on;
    s.buzzer_trigger = buzz;
    return s;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      fail_count++;
    end
  endfunction

  task automatic send_request(logic [1:0] kind, logic up, logic [7:0] x, logic [7:0] y);
    ctc_in_t req;
    int gap;
    req.kind = kind;
    req.step_up = up;
    req.touch_x = x;
    req.touch_y = y;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item <= req;
    do @(posedge clk); while (in_stall);
    pending_status.push_back(next_status(req));
  endtask

  task automatic tick();
    send_request(KIND_TICK, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 239)),
                 8'($urandom_range(0, 239)));
  endtask

  task automatic turn(logic up);
    send_request(KIND_ENCODER, up, 8'($urandom_range(0, 239)), 8'($urandom_range(0, 239)));
  endtask

  task automatic tap(logic [7:0] x, logic [7:0] y);
    send_request(KIND_TAP, 1'($urandom_range(0, 1)), x, y);
  endtask

  task automatic press_button();
    tap(8'($urandom_range(BTN_X_LO, BTN_X_HI)), 8'($urandom_range(BTN_Y_LO, BTN_Y_HI)));
  endtask

  task automatic tap_digit(logic seconds);
    tap(seconds ? 8'($urandom_range(DIGIT_X_MID, 239)) :
                  8'($urandom_range(0, DIGIT_X_MID - 1)),
        8'($urandom_range(DIGIT_Y_LO, DIGIT_Y_HI)));
  endtask

  task automatic wait_idle(int settle);
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_status.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_config(logic [15:0] ms_per_sec, logic [15:0] blink_half);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= CFG_MS_PER_SECOND;
    cfg_wdata <= ms_per_sec;
    @(negedge clk);
    cfg_index <= CFG_BLINK_HALF_PERIOD;
    cfg_wdata <= blink_half;
    @(negedge clk);
    cfg_we <= 1'b0;
    tm_ms_per_sec = ms_per_sec;
    tm_blink_half = blink_half;
  endtask

  task automatic noise_request();
    case ($urandom_range(0, 3))
      0: send_request(KindUnused, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 239)),
                      8'($urandom_range(0, 239)));
      1: tap(8'($urandom_range(0, 239)), 8'($urandom_range(0, 239)));
      2: turn(1'($urandom_range(0, 1)));
      default: tick();
    endcase
  endtask

  // walk the set time toward a target, then press the button
  task automatic steer_request();
    int d;
    if (!target_set) begin
      tgt_min = ($urandom_range(0, 9) == 0) ? 7'($urandom_range(0, 99)) : 7'd0;
      tgt_sec = ($urandom_range(0, 5) == 0) ? 6'($urandom_range(0, 59)) :
                                              6'($urandom_range(0, 5));
      target_set = 1'b1;
    end
    if (tm_set_min != tgt_min) begin
      if (tm_sec_sel) begin
        tap_digit(1'b0);
      end else begin
        d = (int'(tgt_min) - int'(tm_set_min) + 100) % 100;
        turn(d <= 50);
      end
    end else if (tm_set_sec != tgt_sec) begin
      if (!tm_sec_sel) begin
        tap_digit(1'b1);
      end else begin
        d = (int'(tgt_sec) - int'(tm_set_sec) + 60) % 60;
        turn(d <= 30);
      end
    end else begin
      press_button();
      target_set = 1'b0;
    end
  endtask

  task automatic random_request();
    if (tm_mode == MODE_RUNNING || tm_mode == MODE_DONE) target_set = 1'b0;
    if ($urandom_range(0, 99) < 8) begin
      noise_request();
    end else if (tm_mode == MODE_RUNNING) begin
      if ($urandom_range(0, 99) < 88) tick();
      else press_button();
    end else if (tm_mode == MODE_DONE) begin
      if ($urandom_range(0, 99) < 92) tick();
      else press_button();
    end else begin
      steer_request();
    end
  endtask

  task automatic test_edit_controls();
    tap(8'd0, 8'd0);
    send_request(KindUnused, 1'b1, 8'd239, 8'd239);
    tick();
    tap(BTN_X_LO, BTN_Y_LO);
    turn(1'b0);
    turn(1'b1);
    turn(1'b1);
    tap(DIGIT_X_MID, DIGIT_Y_LO);
    turn(1'b0);
    turn(1'b1);
    turn(1'b1);
    tap(8'd200, DIGIT_Y_LO - 8'd1);
    tap(BTN_X_LO - 8'd1, BTN_Y_LO);
    tap(BTN_X_HI, BTN_Y_HI + 8'd1);
    tap(DIGIT_X_MID - 8'd1, DIGIT_Y_HI);
    turn(1'b0);
  endtask

  task automatic test_countdown_to_done();
    wait_idle(4);
    write_config(16'd0, 16'd0);
    tap(BTN_X_HI, BTN_Y_HI);
    turn(1'b1);
    tick();
    tick();
    tap(8'd200, 8'd90);
    tick();
    tap(BTN_X_LO, BTN_Y_HI);
    tap(DIGIT_X_MID, 8'd100);
    turn(1'b1);
    turn(1'b1);
    press_button();
    tick();
    press_button();
    tick();
    turn(1'b0);
    turn(1'b0);
    press_button();
    tick();
    press_button();
  endtask

  task automatic test_register_change_mid_count();
    wait_idle(4);
    write_config(16'd10, 16'd10);
    tgt_min = 7'd0;
    tgt_sec = 6'd3;
    target_set = 1'b1;
    while (target_set) steer_request();
    repeat (6) tick();
    wait_idle(4);
    write_config(16'd4, 16'd10);
    while (tm_mode != MODE_DONE) tick();
    repeat (6) tick();
    wait_idle(4);
    write_config(16'd4, 16'd2);
    repeat (5) tick();
    press_button();
  endtask

  task automatic test_random_traffic();
    logic [15:0] ms_set[7] = '{16'd1, 16'd2, 16'd1, 16'd65535, 16'd3, 16'd1, 16'd4};
    logic [15:0] blink_set[7] = '{16'd1, 16'd3, 16'd2, 16'd65535, 16'd1, 16'd6, 16'd2};
    int count_set[7] = '{200, 180, 180, 100, 180, 200, 160};
    for (int p = 0; p < 7; p++) begin
      wait_idle(4);
      write_config(ms_set[p], blink_set[p]);
      repeat (count_set[p]) random_request();
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_status.size() == 0) begin
        $error("status with no request outstanding");
        fail_count++;
      end else begin
        check_field("mode", pending_status[0].mode, out_item.mode);
        check_field("minutes_shown", pending_status[0].minutes_shown,
                    out_item.minutes_shown);
        check_field("seconds_shown", pending_status[0].seconds_shown,
                    out_item.seconds_shown);
        check_field("highlight", pending_status[0].highlight, out_item.highlight);
        check_field("button_label", pending_status[0].button_label, out_item.button_label);
        check_field("digits_on", pending_status[0].digits_on, out_item.digits_on);
        check_field("buzzer_trigger", pending_status[0].buzzer_trigger,
                    out_item.buzzer_trigger);
        void'(pending_status.pop_front());
      end
    end
  end

  always @(negedge clk) begin
    if ($urandom_range(0, 299) == 0) quiet <= ~quiet;
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else if (quiet) begin
      out_stall <= 1'b0;
    end else begin
      stall_roll = $urandom_range(0, 99);
      if (stall_roll < 70) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= 1'b1;
        stall_left = (stall_roll < 95) ? $urandom_range(0, 2) : $urandom_range(10, 40);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchdogLimit) begin
      $display("simulation failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_edit_controls();
    test_countdown_to_done();
    test_register_change_mid_count();
    test_random_traffic();
    wait_idle(10);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
